>>> sv/grhist_pkg.sv
// ----------------------------------------------------------------------------
// grhist_pkg
// Shared sizes and types of the grouped histogram with running mode.
// ----------------------------------------------------------------------------
package grhist_pkg;

  // group and code space
  localparam int GROUPS     = 16;
  localparam int GRP_W      = 4;
  localparam int CODE_W     = 15;
  localparam int COUNT_BITS = 16;
  localparam int OUT_CNT_W  = 16;

  // count memory: one counter per (group, code)
  localparam int CNT_ADDR_W = GRP_W + CODE_W;
  localparam int CNT_DEPTH  = GROUPS * (2 ** CODE_W);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CNT_ADDR_W-1:0] CLR_LAST  = CNT_ADDR_W'(CNT_DEPTH - 1);

  // item mode
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CODE_W-1:0]     code_t;

  // one result word
  typedef struct packed {
    logic                 found;
    code_t                code;
    logic [OUT_CNT_W-1:0] count;
  } res_t;

endpackage

>>> sv/grouped_histogram_running_mode.sv
// The count memory read is registered, and the modify result loads the
// output register, or the skid word while held. Items: a new item is taken
// only once the last one is written back (count memory read, then modify and
// write back in the next cycle; the next read waits for that write). Reset:
// the group bests clear at once; the count memory is then cleared one entry
// a cycle, 524288 entries, with in_tready low until that sweep is done.
// ----------------------------------------------------------------------------
// grouped_histogram_running_mode
// Per-group histogram of destination codes with a running most-frequent code.
// ----------------------------------------------------------------------------
module grouped_histogram_running_mode
  import grhist_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] nationality_id, [18:4] dest_code, rest zero
  input  logic        in_tuser,   // [0] mode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] best_code, [30:15] peak_count, rest zero
  output logic        out_tuser   // [0] found
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_ADDR_W-1:0] clr_addr_r;

  // latched item
  logic             mode_r;
  logic [GRP_W-1:0] grp_r;
  code_t            code_r;

  // group bests
  count_t best_cnt_r  [GROUPS];
  code_t  best_code_r [GROUPS];

  // output register and skid word
  logic out_valid_r, out_valid_nxt;
  res_t out_r;
  logic pend_valid_r, pend_valid_nxt;
  res_t pend_r;

  // memory ports
  logic                  ram_we, ram_re;
  logic [CNT_ADDR_W-1:0] ram_waddr, ram_raddr;
  count_t                ram_wdata, ram_rdata;

  logic   accept, out_free, grp_ok, is_rec, upd;
  count_t cnt_new, cur_cnt, res_cnt;
  code_t  cur_code, res_code;
  res_t   res;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !pend_valid_r;

  grhist_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(CNT_DEPTH)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // read the counter of the incoming word
  assign ram_re    = accept;
  assign ram_raddr = {in_tdata[3:0], in_tdata[18:4]};

  // modify: saturating increment and best compare
  assign grp_ok   = 32'(grp_r) < GROUPS;
  assign is_rec   = (mode_r == MODE_RECORD) && grp_ok;
  assign cnt_new  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
  assign cur_cnt  = best_cnt_r[grp_r];
  assign cur_code = best_code_r[grp_r];
  assign upd      = is_rec &&
                    ((cnt_new > cur_cnt) || ((cnt_new == cur_cnt) && (code_r < cur_code)));
  assign res_cnt  = upd ? cnt_new : cur_cnt;
  assign res_code = upd ? code_r  : cur_code;

  always_comb begin
    res.found = grp_ok && (res_cnt != '0);
    res.code  = res.found ? res_code : '0;
    res.count = res.found ? OUT_CNT_W'(res_cnt) : '0;
  end

  // write back the counter, or clear during the sweep
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == ST_RMW) && is_rec;
      ram_waddr = {grp_r, code_r};
      ram_wdata = cnt_new;
    end
  end

  // sequencer
  always_comb begin
    case (state_r)
      ST_CLEAR: state_nxt = (clr_addr_r == CLR_LAST) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:  state_nxt = accept ? ST_RMW : ST_IDLE;
      ST_RMW:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // output valid and skid valid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    if (state_r == ST_RMW) begin
      out_valid_nxt = 1'b1;
      if (!out_free) begin
        pend_valid_nxt = 1'b1;
      end
    end else if (pend_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // group bests, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GROUPS; g++) begin
        best_cnt_r[g]  <= '0;
        best_code_r[g] <= '0;
      end
    end else if ((state_r == ST_RMW) && upd) begin
      best_cnt_r[grp_r]  <= cnt_new;
      best_code_r[grp_r] <= code_r;
    end
  end

  // payload: latch the item, load the result words
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_tuser;
      grp_r  <= in_tdata[3:0];
      code_r <= in_tdata[18:4];
    end
    if (state_r == ST_RMW) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        pend_r <= res;
      end
    end else if (pend_valid_r && out_free) begin
      out_r <= pend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.found;
  assign out_tdata  = {1'b0, out_r.count, out_r.code};

endmodule

>>> sv/grhist_ram.sv
// ----------------------------------------------------------------------------
// grhist_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module grhist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grouped_histogram_running_mode. A queue of pending
// words feeds a stream driver; every accepted record word updates a local
// histogram and running best per group, and each accepted word queues its
// expected result word. A monitor compares each result word, field by field,
// with the oldest expectation. Directed words hit the field extremes and tie
// rules, and a random phase of records and queries follows, with random idle
// and stall bursts.
// ----------------------------------------------------------------------------
module tb;
  import grhist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             mode;
    logic [GRP_W-1:0] grp;
    code_t            code;
  } item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  // stimulus and expectation stores
  item_t  pending_q[$];
  res_t   expected_best_q[$];
  item_t  cur_word;
  bit     idle_on = 1'b1;
  int     src_gap = 0;
  int     snk_gap = 0;
  int     n_errors = 0;

  // local copy of the histogram and the running best per group
  count_t code_tally[logic [CNT_ADDR_W-1:0]];
  count_t grp_best_cnt[GROUPS];
  code_t  grp_best_code[GROUPS];

  grouped_histogram_running_mode u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // count a record word into the local histogram and return the group's best
  function automatic res_t update_best(item_t it);
    logic [CNT_ADDR_W-1:0] key;
    count_t                cnt;
    res_t                  r;
    key = {it.grp, it.code};
    if (it.mode == MODE_RECORD) begin
      cnt = code_tally.exists(key) ? code_tally[key] : '0;
      if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
      code_tally[key] = cnt;
      if (cnt > grp_best_cnt[it.grp] ||
          (cnt == grp_best_cnt[it.grp] && it.code < grp_best_code[it.grp])) begin
        grp_best_cnt[it.grp]  = cnt;
        grp_best_code[it.grp] = it.code;
      end
    end
    r.found = (grp_best_cnt[it.grp] != '0);
    r.code  = r.found ? grp_best_code[it.grp] : '0;
    r.count = r.found ? grp_best_cnt[it.grp] : '0;
    return r;
  endfunction

  // driver: predict on each accepted word, then present the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_best_q.push_back(update_best(cur_word));
      if (!in_tvalid || in_tready) begin
        if (src_gap != 0) begin
          src_gap   <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_word  = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, cur_word.code, cur_word.grp};
          in_tuser  <= cur_word.mode;
          if (idle_on && $urandom_range(0, 5) == 0)
            src_gap <= $urandom_range(1, 15);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word, then decide the next stall
  always @(posedge clk) begin
    res_t exp_w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      snk_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_best_q.size() == 0) begin
          $error("unexpected result word: tdata %h tuser %b", out_tdata, out_tuser);
          n_errors++;
        end else begin
          exp_w = expected_best_q.pop_front();
          if (out_tuser !== exp_w.found) begin
            $error("found: expected %0d, got %0d", exp_w.found, out_tuser);
            n_errors++;
          end
          if (out_tdata[14:0] !== exp_w.code) begin
            $error("best_code: expected %0d, got %0d", exp_w.code, out_tdata[14:0]);
            n_errors++;
          end
          if (out_tdata[30:15] !== exp_w.count) begin
            $error("peak_count: expected %0d, got %0d", exp_w.count, out_tdata[30:15]);
            n_errors++;
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap    <= snk_gap - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        snk_gap    <= $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic mode, logic [GRP_W-1:0] grp, code_t code);
    item_t it;
    it.mode = mode;
    it.grp  = grp;
    it.code = code;
    pending_q.push_back(it);
  endtask

  // hold until every queued word is taken and every result is back
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || expected_best_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    code_t pool[6];
    int    pick;
    for (int g = 0; g < GROUPS; g++) begin
      grp_best_cnt[g]  = '0;
      grp_best_code[g] = '0;
    end
    pool[0] = '0;
    pool[1] = 15'h7FFF;
    for (int k = 2; k < 6; k++) pool[k] = code_t'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty groups, field extremes, tie rules
    push_item(MODE_QUERY,  4'd0,  15'h7FFF);
    push_item(MODE_QUERY,  4'd15, 15'h0000);
    push_item(MODE_RECORD, 4'd15, 15'h7FFF);
    push_item(MODE_RECORD, 4'd15, 15'h0000);
    push_item(MODE_QUERY,  4'd15, 15'h5555);
    push_item(MODE_RECORD, 4'd0,  15'h0000);
    push_item(MODE_RECORD, 4'd0,  15'h0000);
    push_item(MODE_RECORD, 4'd0,  15'h7FFF);
    push_item(MODE_RECORD, 4'd1,  15'd1200);
    push_item(MODE_RECORD, 4'd1,  15'd600);
    push_item(MODE_RECORD, 4'd1,  15'd2400);
    push_item(MODE_RECORD, 4'd1,  15'd2400);
    push_item(MODE_RECORD, 4'd1,  15'd600);
    push_item(MODE_RECORD, 4'd1,  15'd1200);
    push_item(MODE_RECORD, 4'd1,  15'd1200);
    push_item(MODE_QUERY,  4'd1,  15'h2AAA);
    push_item(MODE_RECORD, 4'd10, 15'h2AAA);
    push_item(MODE_RECORD, 4'd5,  15'h5555);
    push_item(MODE_QUERY,  4'd10, 15'h0000);
    push_item(MODE_QUERY,  4'd7,  15'h7FFF);
    drain();

    // random records and queries; the last stretch runs without idling
    idle_on = 1'b1;
    for (int n = 0; n < 1300; n++) begin
      if (n == 1150) begin
        while (pending_q.size() != 0) @(negedge clk);
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25)
        push_item(MODE_QUERY, GRP_W'($urandom), code_t'($urandom));
      else if (pick < 40)
        push_item(MODE_RECORD, GRP_W'($urandom), code_t'($urandom));
      else
        push_item(MODE_RECORD, GRP_W'($urandom_range(0, 3) * 5),
                  pool[3'($urandom_range(0, 5))]);
    end

    drain();
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // clear sweep plus the item traffic stay well inside this bound
  initial begin
    #40_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/grhist_pkg.sv
sv/grhist_ram.sv
sv/grouped_histogram_running_mode.sv
sim/tb.sv
